// ===== hw/rtl/ecomp_pkg.sv =====
// ----------------------------------------------------------------------------
// ecomp_pkg: environment sensor compensation package
// Payload types, register indexes, modes and 64-bit helper functions.
// ----------------------------------------------------------------------------
package ecomp_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_TAIL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL        = 3'd4;

    localparam logic [1:0] MODE_TEMP  = 2'd0;
    localparam logic [1:0] MODE_PRESS = 2'd1;
    localparam logic [1:0] MODE_HUM   = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [63:0] K_PRESS_FINE_OFS = 64'd128000;
    localparam logic [63:0] K_PRESS_BASE     = 64'd1048576;
    localparam logic [63:0] K_PRESS_SCALE    = 64'd3125;
    localparam logic [63:0] K_HUM_FINE_OFS   = 64'd76800;
    localparam logic [63:0] K_HUM_MAX        = 64'd419430400;
    localparam logic [63:0] K_HUM_OFS_A      = 64'd2097152;
    localparam logic [63:0] K_HUM_RND_A      = 64'd16384;
    localparam logic [63:0] K_HUM_OFS_B      = 64'd32768;
    localparam logic [63:0] K_HUM_RND_B      = 64'd8192;
    localparam logic [63:0] K_TEMP_RND       = 64'd128;

    typedef struct packed {
        logic [1:0]  mode;
        logic [19:0] raw_reading;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] compensated_value;
        logic               pressure_invalid;
    } out_item_t;

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        asr64 = 64'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] x);
        sx16 = {{48{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx12(input logic [11:0] x);
        sx12 = {{52{x[11]}}, x};
    endfunction

    function automatic logic [63:0] sx8(input logic [7:0] x);
        sx8 = {{56{x[7]}}, x};
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] x);
        if (x[63])
        begin
            sat32 = (x < 64'hFFFF_FFFF_8000_0000) ? 32'h8000_0000 : x[31:0];
        end
        else
        begin
            sat32 = (x > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : x[31:0];
        end
    endfunction

endpackage

// ===== hw/rtl/environment_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// environment_sensor_compensation
// Trim compensation of temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// channel  | signals                           | transaction
// ---------+-----------------------------------+------------------------------
// in       | in_valid, in_ready, in_data       | one tagged raw reading
// out      | out_valid, out_ready, out_data    | one compensated result
// cfg      | cfg_we, cfg_index, cfg_wdata      | one calibration word write
//
// One shared shift-add 64x64 multiplier and one restoring 64/64 divider
// run under a step sequencer (issue, compute, write back); pressure takes up
// to 11 ops. in_ready is high only while idle; a finished result waits in
// the output register while the next reading is accepted. Reset clears the
// control state, valid flag and calibration words, not the datapath.
// ----------------------------------------------------------------------------
module environment_sensor_compensation (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ecomp_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ecomp_pkg::out_item_t                 out_data,
    input  logic                                 cfg_we,
    input  logic [ecomp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ecomp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  pc_reg, pc_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  mode_reg, mode_next;
    logic [19:0] raw_reg, raw_next;
    logic [31:0] fine_reg, fine_next;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_lo_reg, press_hi_reg, hum_cal_reg;
    logic [15:0] press_tail_reg;

    logic [63:0] t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic [63:0] t3_reg, t3_next, t4_reg, t4_next, t5_reg, t5_next;

    logic [63:0] mula_reg, mula_next, mulb_reg, mulb_next, acc_reg, acc_next;
    logic [63:0] num_reg, num_next, rem_reg, rem_next, den_reg, den_next;
    logic        div_neg_reg, div_neg_next, op_div_reg, op_div_next;

    logic        res_bad_reg, res_bad_next;
    logic [31:0] res_val_reg, res_val_next;

    logic                 out_valid_reg, out_valid_next;
    ecomp_pkg::out_item_t out_reg, out_next;

    logic [63:0] c_t1, c_t2, c_t3;
    logic [63:0] c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;
    logic [63:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;
    logic [63:0] fine64, raw64, v1p, xh;
    logic [63:0] op_a, op_b;
    logic        op_is_div;
    logic [63:0] ures;
    logic [64:0] rem_sh, rem_diff;
    logic        fin;
    logic [63:0] wtmp, wtmp2;

    assign c_t1 = {48'd0, temp_cal_reg[15:0]};
    assign c_t2 = ecomp_pkg::sx16(temp_cal_reg[31:16]);
    assign c_t3 = ecomp_pkg::sx16(temp_cal_reg[47:32]);
    assign c_p1 = {48'd0, press_lo_reg[15:0]};
    assign c_p2 = ecomp_pkg::sx16(press_lo_reg[31:16]);
    assign c_p3 = ecomp_pkg::sx16(press_lo_reg[47:32]);
    assign c_p4 = ecomp_pkg::sx16(press_lo_reg[63:48]);
    assign c_p5 = ecomp_pkg::sx16(press_hi_reg[15:0]);
    assign c_p6 = ecomp_pkg::sx16(press_hi_reg[31:16]);
    assign c_p7 = ecomp_pkg::sx16(press_hi_reg[47:32]);
    assign c_p8 = ecomp_pkg::sx16(press_hi_reg[63:48]);
    assign c_p9 = ecomp_pkg::sx16(press_tail_reg);
    assign c_h1 = {56'd0, hum_cal_reg[7:0]};
    assign c_h2 = ecomp_pkg::sx16(hum_cal_reg[23:8]);
    assign c_h3 = {56'd0, hum_cal_reg[31:24]};
    assign c_h4 = ecomp_pkg::sx12(hum_cal_reg[43:32]);
    assign c_h5 = ecomp_pkg::sx12(hum_cal_reg[55:44]);
    assign c_h6 = ecomp_pkg::sx8(hum_cal_reg[63:56]);

    assign fine64 = {{32{fine_reg[31]}}, fine_reg};
    assign raw64  = {44'd0, raw_reg};
    assign v1p    = fine64 - ecomp_pkg::K_PRESS_FINE_OFS;
    assign xh     = fine64 - ecomp_pkg::K_HUM_FINE_OFS;

    assign ures = op_div_reg ? (div_neg_reg ? (64'd0 - num_reg) : num_reg) : acc_reg;

    assign rem_sh   = {rem_reg, num_reg[63]};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // operand select per step
    always_comb
    begin
        op_a      = 64'd0;
        op_b      = 64'd0;
        op_is_div = 1'b0;
        case (mode_reg)
            ecomp_pkg::MODE_TEMP:
            begin
                case (pc_reg)
                    4'd0:
                    begin
                        op_a = {47'd0, raw_reg[19:3]} - {47'd0, temp_cal_reg[15:0], 1'b0};
                        op_b = c_t2;
                    end
                    4'd1:
                    begin
                        op_a = {48'd0, raw_reg[19:4]} - c_t1;
                        op_b = op_a;
                    end
                    default:
                    begin
                        op_a = t1_reg;
                        op_b = c_t3;
                    end
                endcase
            end
            ecomp_pkg::MODE_PRESS:
            begin
                case (pc_reg)
                    4'd0:
                    begin
                        op_a = v1p;
                        op_b = v1p;
                    end
                    4'd1:
                    begin
                        op_a = t0_reg;
                        op_b = c_p6;
                    end
                    4'd2:
                    begin
                        op_a = v1p;
                        op_b = c_p5;
                    end
                    4'd3:
                    begin
                        op_a = t0_reg;
                        op_b = c_p3;
                    end
                    4'd4:
                    begin
                        op_a = v1p;
                        op_b = c_p2;
                    end
                    4'd5:
                    begin
                        op_a = (64'd1 << 47) + t2_reg;
                        op_b = c_p1;
                    end
                    4'd6:
                    begin
                        op_a = ((ecomp_pkg::K_PRESS_BASE - raw64) << 31) - t1_reg;
                        op_b = ecomp_pkg::K_PRESS_SCALE;
                    end
                    4'd7:
                    begin
                        op_a      = t3_reg;
                        op_b      = t2_reg;
                        op_is_div = 1'b1;
                    end
                    4'd8:
                    begin
                        op_a = c_p9;
                        op_b = ecomp_pkg::asr64(t3_reg, 13);
                    end
                    4'd9:
                    begin
                        op_a = t4_reg;
                        op_b = ecomp_pkg::asr64(t3_reg, 13);
                    end
                    default:
                    begin
                        op_a = c_p8;
                        op_b = t3_reg;
                    end
                endcase
            end
            default:
            begin
                case (pc_reg)
                    4'd0:
                    begin
                        op_a = c_h5;
                        op_b = xh;
                    end
                    4'd1:
                    begin
                        op_a = xh;
                        op_b = c_h6;
                    end
                    4'd2:
                    begin
                        op_a = xh;
                        op_b = c_h3;
                    end
                    4'd3:
                    begin
                        op_a = t1_reg;
                        op_b = t2_reg;
                    end
                    4'd4:
                    begin
                        op_a = t1_reg;
                        op_b = c_h2;
                    end
                    4'd5:
                    begin
                        op_a = t0_reg;
                        op_b = t1_reg;
                    end
                    4'd6:
                    begin
                        op_a = t2_reg;
                        op_b = t2_reg;
                    end
                    default:
                    begin
                        op_a = t2_reg;
                        op_b = c_h1;
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        raw_next       = raw_reg;
        fine_next      = fine_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        t3_next        = t3_reg;
        t4_next        = t4_reg;
        t5_next        = t5_reg;
        mula_next      = mula_reg;
        mulb_next      = mulb_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        div_neg_next   = div_neg_reg;
        op_div_next    = op_div_reg;
        res_bad_next   = res_bad_reg;
        res_val_next   = res_val_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        fin            = 1'b0;
        wtmp           = 64'd0;
        wtmp2          = 64'd0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = in_data.mode;
                    raw_next  = in_data.raw_reading;
                    pc_next   = 4'd0;
                    if (in_data.mode != ecomp_pkg::MODE_NONE)
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                cnt_next     = 6'd0;
                op_div_next  = op_is_div;
                mula_next    = op_a;
                mulb_next    = op_b;
                acc_next     = 64'd0;
                num_next     = op_a[63] ? (64'd0 - op_a) : op_a;
                den_next     = op_b[63] ? (64'd0 - op_b) : op_b;
                div_neg_next = op_a[63] ^ op_b[63];
                rem_next     = 64'd0;
                state_next   = op_is_div ? S_DIV : S_MUL;
            end
            S_MUL:
            begin
                acc_next  = acc_reg + (mulb_reg[0] ? mula_reg : 64'd0);
                mula_next = {mula_reg[62:0], 1'b0};
                mulb_next = {1'b0, mulb_reg[63:1]};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = S_WB;
                end
            end
            S_DIV:
            begin
                if (!rem_diff[64])
                begin
                    rem_next = rem_diff[63:0];
                    num_next = {num_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[63:0];
                    num_next = {num_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                res_bad_next = 1'b0;
                case (mode_reg)
                    ecomp_pkg::MODE_TEMP:
                    begin
                        case (pc_reg)
                            4'd0: t0_next = ecomp_pkg::asr64(ures, 11);
                            4'd1: t1_next = ecomp_pkg::asr64(ures, 12);
                            default:
                            begin
                                wtmp      = t0_reg + ecomp_pkg::asr64(ures, 14);
                                fine_next = ecomp_pkg::sat32(wtmp);
                                wtmp2     = {{32{fine_next[31]}}, fine_next};
                                wtmp2     = (wtmp2 << 2) + wtmp2 + ecomp_pkg::K_TEMP_RND;
                                res_val_next = ecomp_pkg::sat32(ecomp_pkg::asr64(wtmp2, 8));
                                fin       = 1'b1;
                            end
                        endcase
                    end
                    ecomp_pkg::MODE_PRESS:
                    begin
                        case (pc_reg)
                            4'd0: t0_next = ures;
                            4'd1: t1_next = ures;
                            4'd2: t1_next = t1_reg + (ures << 17) + (c_p4 << 35);
                            4'd3: t2_next = ecomp_pkg::asr64(ures, 8);
                            4'd4: t2_next = t2_reg + (ures << 12);
                            4'd5:
                            begin
                                wtmp    = ecomp_pkg::asr64(ures, 33);
                                t2_next = wtmp;
                                if (wtmp == 64'd0)
                                begin
                                    res_bad_next = 1'b1;
                                    res_val_next = 32'd0;
                                    fin          = 1'b1;
                                end
                            end
                            4'd6: t3_next = ures;
                            4'd7: t3_next = ures;
                            4'd8: t4_next = ures;
                            4'd9: t4_next = ecomp_pkg::asr64(ures, 25);
                            default:
                            begin
                                t5_next = ecomp_pkg::asr64(ures, 19);
                                wtmp    = ecomp_pkg::asr64(t3_reg + t4_reg + t5_next, 8)
                                          + (c_p7 << 4);
                                res_val_next = ecomp_pkg::sat32(wtmp);
                                fin          = 1'b1;
                            end
                        endcase
                    end
                    default:
                    begin
                        case (pc_reg)
                            4'd0:
                            begin
                                wtmp    = (raw64 << 14) - (c_h4 << 20) - ures
                                          + ecomp_pkg::K_HUM_RND_A;
                                t0_next = ecomp_pkg::asr64(wtmp, 15);
                            end
                            4'd1: t1_next = ecomp_pkg::asr64(ures, 10);
                            4'd2: t2_next = ecomp_pkg::asr64(ures, 11) + ecomp_pkg::K_HUM_OFS_B;
                            4'd3: t1_next = ecomp_pkg::asr64(ures, 10) + ecomp_pkg::K_HUM_OFS_A;
                            4'd4: t1_next = ecomp_pkg::asr64(ures + ecomp_pkg::K_HUM_RND_B, 14);
                            4'd5:
                            begin
                                t0_next = ures;
                                t2_next = ecomp_pkg::asr64(ures, 15);
                            end
                            4'd6: t2_next = ecomp_pkg::asr64(ures, 7);
                            default:
                            begin
                                wtmp = t0_reg - ecomp_pkg::asr64(ures, 4);
                                if (wtmp[63])
                                begin
                                    wtmp = 64'd0;
                                end
                                else if (wtmp > ecomp_pkg::K_HUM_MAX)
                                begin
                                    wtmp = ecomp_pkg::K_HUM_MAX;
                                end
                                res_val_next = {12'd0, wtmp[31:12]};
                                fin          = 1'b1;
                            end
                        endcase
                    end
                endcase
                pc_next    = pc_reg + 4'd1;
                state_next = fin ? S_PUT : S_ISSUE;
            end
            S_PUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_next.kind             = mode_reg;
                    out_next.compensated_value = res_val_reg;
                    out_next.pressure_invalid = res_bad_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pc_reg         <= 4'd0;
            cnt_reg        <= 6'd0;
            fine_reg       <= 32'd0;
            out_valid_reg  <= 1'b0;
            temp_cal_reg   <= 48'd0;
            press_lo_reg   <= 64'd0;
            press_hi_reg   <= 64'd0;
            press_tail_reg <= 16'd0;
            hum_cal_reg    <= 64'd0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            fine_reg      <= fine_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ecomp_pkg::REG_TEMP_CAL:       temp_cal_reg   <= cfg_wdata[47:0];
                    ecomp_pkg::REG_PRESS_CAL_LOW:  press_lo_reg   <= cfg_wdata;
                    ecomp_pkg::REG_PRESS_CAL_HIGH: press_hi_reg   <= cfg_wdata;
                    ecomp_pkg::REG_PRESS_CAL_TAIL: press_tail_reg <= cfg_wdata[15:0];
                    ecomp_pkg::REG_HUM_CAL:        hum_cal_reg    <= cfg_wdata;
                    default:                       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        raw_reg     <= raw_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        t3_reg      <= t3_next;
        t4_reg      <= t4_next;
        t5_reg      <= t5_next;
        mula_reg    <= mula_next;
        mulb_reg    <= mulb_next;
        acc_reg     <= acc_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        div_neg_reg <= div_neg_next;
        op_div_reg  <= op_div_next;
        res_bad_reg <= res_bad_next;
        res_val_reg <= res_val_next;
        out_reg     <= out_next;
    end

endmodule

// ===== hw/rtl/ecomp_checker.sv =====
// ----------------------------------------------------------------------------
// ecomp_checker
// Port-level checks for environment_sensor_compensation.
// ----------------------------------------------------------------------------
module ecomp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input ecomp_pkg::in_item_t              in_data,
    input logic                             out_valid,
    input logic                             out_ready,
    input ecomp_pkg::out_item_t             out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.mode != ecomp_pkg::MODE_NONE |=> !in_ready)
        else $error("ready while a reading is in progress");

    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.kind != ecomp_pkg::MODE_NONE)
        else $error("result for unused mode");

    a_invalid_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.pressure_invalid |->
            out_data.kind == ecomp_pkg::MODE_PRESS && out_data.compensated_value == 32'sd0)
        else $error("invalid flag on non-pressure or nonzero result");

endmodule

bind environment_sensor_compensation ecomp_checker u_ecomp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
